@@ rtl/lhdf_pkg.sv @@
// ============================================================================
// lhdf_pkg: shared types and constants for the line hash duplicate filter
// FNV-1a constants, controller state encoding, command and status bundles.
// ============================================================================
`default_nettype none

package lhdf_pkg;

   // FNV-1a 32-bit constants
   localparam logic [31:0] FNV_BASIS = 32'd2166136261;
   localparam logic [31:0] FNV_PRIME = 32'd16777619;

   // default ring depth
   localparam int RING_SLOTS_DEF = 32;

   // controller states
   typedef enum logic {
      ST_IDLE,
      ST_LOOKUP
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic fold;        // request accepted: fold its byte
      logic start_scan;  // line end accepted: latch key, restart scan
      logic scan;        // step the ring scan
      logic commit;      // load result, update ring
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic scan_done;   // every valid entry compared
      logic out_busy;    // result register holds an untaken result
   } sts_type;

   // one FNV-1a step: xor the byte in, multiply modulo 2^32
   function automatic logic [31:0] fnv_fold(input logic [31:0] hash,
                                             input logic [7:0]  data);
      logic [31:0] mixed;
      mixed    = hash ^ {24'd0, data};
      fnv_fold = mixed * FNV_PRIME;
   endfunction

endpackage

`default_nettype wire

@@ rtl/lhdf_req_if.sv @@
// ============================================================================
// lhdf_req_if: request channel of the line hash duplicate filter
// One byte of a text line per request, with presence and end-of-line flags.
// ============================================================================
`default_nettype none

interface lhdf_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_byte;
   logic       byte_present;
   logic       end_of_line;

   modport source (output valid, output char_byte, output byte_present,
                   output end_of_line, input ready);
   modport sink   (input valid, input char_byte, input byte_present,
                   input end_of_line, output ready);
endinterface

`default_nettype wire

@@ rtl/lhdf_rsp_if.sv @@
// ============================================================================
// lhdf_rsp_if: result channel of the line hash duplicate filter
// One result per completed line: duplicate flag and final line hash.
// ============================================================================
`default_nettype none

interface lhdf_rsp_if;
   logic        valid;
   logic        ready;
   logic        is_duplicate;
   logic [31:0] line_hash;

   modport source (output valid, output is_duplicate, output line_hash,
                   input ready);
   modport sink   (input valid, input is_duplicate, input line_hash,
                   output ready);
endinterface

`default_nettype wire

@@ rtl/lhdf_ctrl.sv @@
// ============================================================================
// lhdf_ctrl: controller of the line hash duplicate filter
// Takes requests while idle and sequences the ring lookup at each line end.
// ============================================================================
`default_nettype none

module lhdf_ctrl
   import lhdf_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   input  wire logic    req_eol,
   output logic         req_ready,
   input  wire sts_type sts,
   output cmd_type      cmd
);

   state_type state_ff;
   state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_eol) state_in = ST_LOOKUP;
         end
         ST_LOOKUP: begin
            if (sts.scan_done && !sts.out_busy) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready      = 1'b1;
            cmd.fold       = req_valid;
            cmd.start_scan = req_valid && req_eol;
         end
         ST_LOOKUP: begin
            cmd.scan   = 1'b1;
            cmd.commit = sts.scan_done && !sts.out_busy;
         end
         default: begin
            cmd       = '0;
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

`default_nettype wire

@@ rtl/lhdf_datapath.sv @@
// ============================================================================
// lhdf_datapath: hash, ring memory and result register
// Folds bytes into the FNV-1a hash, scans the ring one entry a cycle and
// holds the result until it is taken.
// ============================================================================
`default_nettype none

module lhdf_datapath
   import lhdf_pkg::*;
#(
   parameter int RING_SLOTS = RING_SLOTS_DEF
)
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic [7:0]  char_byte,
   input  wire logic        byte_present,
   input  wire cmd_type     cmd,
   output sts_type          sts,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_is_duplicate,
   output logic [31:0]      rsp_line_hash
);

   localparam int ADDR_W = (RING_SLOTS > 1) ? $clog2(RING_SLOTS) : 1;
   localparam int CNT_W  = $clog2(RING_SLOTS + 1);
   localparam logic [CNT_W-1:0]  SLOTS_C = CNT_W'(RING_SLOTS);
   localparam logic [ADDR_W-1:0] LAST_C  = ADDR_W'(RING_SLOTS - 1);

   logic [31:0]       hash_ff, hash_in;
   logic [31:0]       key_ff, key_in;
   logic [ADDR_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  scan_ff, scan_in;
   logic              pend_ff, pend_in;
   logic              match_ff, match_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_dup_ff, rsp_dup_in;
   logic [31:0]       rsp_hash_ff, rsp_hash_in;
   logic [31:0]       rd_data_ff;
   logic [31:0]       ring_mem [RING_SLOTS];

   logic [31:0]       fold_hash;
   logic              scan_more;
   logic              scan_rd;
   logic              mem_we;
   logic [ADDR_W-1:0] rd_addr;

   // byte fold
   assign fold_hash = byte_present ? fnv_fold(hash_ff, char_byte) : hash_ff;

   // scan control: entries 0 .. count-1 are exactly the written ones
   assign scan_more = (scan_ff < count_ff);
   assign scan_rd   = cmd.scan && scan_more;
   assign rd_addr   = scan_ff[ADDR_W-1:0];
   assign mem_we    = cmd.commit && !match_ff;

   // next values
   always_comb begin
      hash_in      = hash_ff;
      key_in       = key_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      scan_in      = scan_ff;
      match_in     = match_ff;
      rsp_dup_in   = rsp_dup_ff;
      rsp_hash_in  = rsp_hash_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      pend_in      = scan_rd;

      if (cmd.fold) begin
         hash_in = cmd.start_scan ? FNV_BASIS : fold_hash;
      end
      if (cmd.start_scan) begin
         key_in   = fold_hash;
         scan_in  = '0;
         match_in = 1'b0;
      end
      if (scan_rd) scan_in = scan_ff + 1'b1;
      if (pend_ff && (rd_data_ff == key_ff)) match_in = 1'b1;

      // line end result and ring update
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
         rsp_dup_in   = match_ff;
         rsp_hash_in  = key_ff;
         if (!match_ff) begin
            head_in = (head_ff == LAST_C) ? '0 : head_ff + 1'b1;
            if (count_ff != SLOTS_C) count_in = count_ff + 1'b1;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff      <= FNV_BASIS;
         head_ff      <= '0;
         count_ff     <= '0;
         scan_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         hash_ff      <= hash_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         scan_ff      <= scan_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      key_ff      <= key_in;
      match_ff    <= match_in;
      rsp_dup_ff  <= rsp_dup_in;
      rsp_hash_ff <= rsp_hash_in;
   end

   // ring memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) ring_mem[head_ff] <= key_ff;
      if (scan_rd) rd_data_ff <= ring_mem[rd_addr];
   end

   // status and outputs
   assign sts.scan_done  = !scan_more && !pend_ff;
   assign sts.out_busy   = rsp_valid_ff && !rsp_ready;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_is_duplicate = rsp_dup_ff;
   assign rsp_line_hash    = rsp_hash_ff;

endmodule

`default_nettype wire

@@ rtl/line_hash_duplicate_filter_top.sv @@
// ============================================================================
// line_hash_duplicate_filter_top: duplicate-line filter on FNV-1a hashes
// Hashes the bytes of each line and flags lines whose hash is among the
// most recent distinct line hashes held in a ring.
// ============================================================================
//
//  channel   direction  payload                                  handshake
//  req_bus   in         char_byte, byte_present, end_of_line      valid/ready
//  rsp_bus   out        is_duplicate, line_hash                   valid/ready
//
//  A request that does not end a line is folded with one FNV-1a multiply.
//  A line end holds off requests while the ring is compared one entry a cycle
//  through the single memory read port, and longer while an earlier result is
//  still untaken.
//  Bytes keep flowing while a result waits; a line end waits for it to go.
//  Synchronous reset; the ring memory needs no clearing pass.
// ============================================================================
`default_nettype none

module line_hash_duplicate_filter_top
   import lhdf_pkg::*;
#(
   parameter int RING_SLOTS = RING_SLOTS_DEF
)
(
   input  wire logic  clock,
   input  wire logic  reset,
   lhdf_req_if.sink   req_bus,
   lhdf_rsp_if.source rsp_bus
);

   cmd_type cmd;
   sts_type sts;

   // controller
   lhdf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_eol   (req_bus.end_of_line),
      .req_ready (req_bus.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // datapath
   lhdf_datapath #(
      .RING_SLOTS (RING_SLOTS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .char_byte        (req_bus.char_byte),
      .byte_present     (req_bus.byte_present),
      .cmd              (cmd),
      .sts              (sts),
      .rsp_valid        (rsp_bus.valid),
      .rsp_ready        (rsp_bus.ready),
      .rsp_is_duplicate (rsp_bus.is_duplicate),
      .rsp_line_hash    (rsp_bus.line_hash)
   );

`ifndef SYNTH
   // a result is never loaded over one still waiting
   a_commit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> !sts.out_busy)
      else $error("result loaded over an untaken result");

   // a line end closes the request side for the lookup
   a_lookup_blocks: assert property (@(posedge clock) disable iff (reset)
      cmd.start_scan |=> !req_bus.ready)
      else $error("request taken during ring lookup");

   // every commit shows a result next cycle
   a_commit_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_bus.valid)
      else $error("committed result not presented");
`endif

endmodule

`default_nettype wire

@@ dv/line_hash_duplicate_filter_top_tb.sv @@
`timescale 1ns / 1ps
// ============================================================================
// line_hash_duplicate_filter_top_tb: self-checking bench for the line filter
// Feeds text lines byte by byte with random gaps and back-pressure, keeps its
// own FNV-1a hash and ring of recent line hashes, and checks every result.
// ============================================================================

module line_hash_duplicate_filter_top_tb;
   import lhdf_pkg::*;

   localparam int RING         = RING_SLOTS_DEF;
   localparam int N_ITEMS      = 1950;
   localparam int POOL_SIZE    = 48;
   localparam int MAX_LINE     = 8;
   localparam int IDLE_LIMIT   = 3000;
   localparam int DRAIN_CYCLES = 64;
   localparam int HOLD_CYCLES  = 300;

   typedef struct packed {
      logic        is_duplicate;
      logic [31:0] line_hash;
   } line_result_type;

   typedef logic [7:0] line_text_type [MAX_LINE];

   // Tracks the running line hash and the ring of recent distinct hashes
   class line_dedup_tracker;
      logic [31:0]     fold_hash;
      logic [31:0]     ring_hash [RING];
      int unsigned     head;
      int unsigned     filled;
      line_result_type expected_lines [$];
      int unsigned     failures;

      function new();
         fold_hash = FNV_BASIS;
         head      = 0;
         filled    = 0;
         failures  = 0;
         foreach (ring_hash[i]) ring_hash[i] = '0;
      endfunction

      // only slots written so far are searched
      function bit seen_recently(logic [31:0] h);
         int unsigned slot;
         for (int unsigned i = 0; i < filled; i++) begin
            slot = (head + RING - 1 - i) % RING;
            if (ring_hash[slot] == h) return 1'b1;
         end
         return 1'b0;
      endfunction

      // fold an accepted request; a line end queues one expected result
      function void absorb_request(logic [7:0] data, logic present, logic last);
         line_result_type r;
         if (present) fold_hash = (fold_hash ^ {24'd0, data}) * FNV_PRIME;
         if (!last) return;
         r.line_hash    = fold_hash;
         r.is_duplicate = seen_recently(fold_hash);
         fold_hash      = FNV_BASIS;
         if (!r.is_duplicate) begin
            ring_hash[head] = r.line_hash;
            head            = (head + 1) % RING;
            if (filled < RING) filled++;
         end
         expected_lines.push_back(r);
      endfunction

      function void check_result(logic dup, logic [31:0] hash);
         line_result_type want;
         if (expected_lines.size() == 0) begin
            $display("%0t ns: unexpected result: expected none, actual dup=%0b hash=%08h",
                     $time, dup, hash);
            failures++;
            return;
         end
         want = expected_lines.pop_front();
         if (dup !== want.is_duplicate) begin
            $display("%0t ns: is_duplicate mismatch: expected %0b, actual %0b",
                     $time, want.is_duplicate, dup);
            failures++;
         end
         if (hash !== want.line_hash) begin
            $display("%0t ns: line_hash mismatch: expected %08h, actual %08h",
                     $time, want.line_hash, hash);
            failures++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;

   lhdf_req_if req_bus ();
   lhdf_rsp_if rsp_bus ();

   line_hash_duplicate_filter_top #(.RING_SLOTS(RING)) u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   line_dedup_tracker tracker;
   int unsigned       items_sent;
   bit                sender_burst;
   bit                hold_off_request;
   line_text_type     pool_text [POOL_SIZE];
   int unsigned       pool_len  [POOL_SIZE];

   // clock
   initial clock = 1'b0;
   always #4 clock = ~clock;

   // mostly short gaps, now and then a long one
   function automatic int unsigned pick_gap(bit no_idle);
      int unsigned r;
      if (no_idle) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // offer one request and wait for it to be taken
   task automatic send_request(input logic [7:0] data, input logic present,
                               input logic last);
      int unsigned gap;
      gap = pick_gap(sender_burst);
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.char_byte    <= data;
      req_bus.byte_present <= present;
      req_bus.end_of_line  <= last;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      tracker.absorb_request(data, present, last);
      items_sent++;
   endtask

   // one line; a sloppy line carries empty requests and may end on a bare line end
   task automatic send_line(input line_text_type text, input int unsigned len,
                            input bit sloppy);
      bit split_end;
      split_end = sloppy && ($urandom_range(0, 2) == 0);
      for (int unsigned k = 0; k < len; k++) begin
         if (sloppy && $urandom_range(0, 4) == 0)
            send_request(8'($urandom_range(0, 255)), 1'b0, 1'b0);
         send_request(text[k], 1'b1, (k == len - 1) && !split_end);
      end
      if (len == 0 || split_end) send_request(8'($urandom_range(0, 255)), 1'b0, 1'b1);
   endtask

   // result side: random stalls, plus one long hold-off on demand
   initial begin
      int unsigned stall_left;
      int unsigned run_left;
      stall_left = 0;
      run_left   = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_bus.valid && rsp_bus.ready)
            tracker.check_result(rsp_bus.is_duplicate, rsp_bus.line_hash);
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            stall_left       = HOLD_CYCLES;
            run_left         = 0;
         end
         if (stall_left == 0 && run_left == 0) begin
            if ($urandom_range(0, 1))
               run_left = $urandom_range(1, ($urandom_range(0, 9) == 0) ? 200 : 20);
            else
               stall_left = pick_gap(1'b0) + 1;
         end
         if (stall_left != 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_bus.ready <= 1'b1;
            run_left--;
         end
      end
   end

   // watchdog: nothing moving on either channel for too long
   initial begin
      int unsigned quiet;
      quiet = 0;
      while (quiet < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("%0t ns: watchdog, no handshake for %0d cycles", $time, IDLE_LIMIT);
      $display("FAILURE");
      $finish;
   end

   // stimulus
   initial begin
      line_text_type txt;
      int unsigned   len;
      int unsigned   pick;
      int unsigned   idx;
      bit            pressure_done;

      tracker          = new();
      items_sent       = 0;
      sender_burst     = 1'b0;
      hold_off_request = 1'b0;
      pressure_done    = 1'b0;

      reset                <= 1'b1;
      req_bus.valid        <= 1'b0;
      req_bus.char_byte    <= 8'd0;
      req_bus.byte_present <= 1'b0;
      req_bus.end_of_line  <= 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // empty line twice: offset basis stored, then found
      send_request(8'h00, 1'b0, 1'b1);
      send_request(8'hFF, 1'b0, 1'b1);
      // request with neither byte nor line end does nothing
      send_request(8'hA5, 1'b0, 1'b0);
      // zero byte is folded like any other
      send_request(8'h00, 1'b1, 1'b1);
      send_request(8'hFF, 1'b1, 1'b0);
      send_request(8'h01, 1'b1, 1'b1);
      send_request(8'h00, 1'b1, 1'b1);
      // absent byte mid-line, then a bare line end
      send_request(8'h80, 1'b1, 1'b0);
      send_request(8'h5A, 1'b0, 1'b0);
      send_request(8'h7F, 1'b1, 1'b0);
      send_request(8'h3C, 1'b0, 1'b1);
      // repeat of an earlier two-byte line
      send_request(8'hFF, 1'b1, 1'b0);
      send_request(8'h01, 1'b1, 1'b1);
      send_request(8'h55, 1'b1, 1'b1);
      send_request(8'hAA, 1'b1, 1'b1);
      send_request(8'h80, 1'b1, 1'b0);
      send_request(8'h7F, 1'b1, 1'b1);

      // ring wrap: more distinct lines than slots, so the oldest fall out
      foreach (txt[k]) txt[k] = 8'h00;
      for (int unsigned n = 0; n < RING + 2; n++) begin
         txt[0] = 8'h40 + n[7:0];
         send_line(txt, 1, 1'b0);
      end
      txt[0] = 8'h40;
      send_line(txt, 1, 1'b0);
      txt[0] = 8'h40 + RING[7:0] + 8'h01;
      send_line(txt, 1, 1'b0);

      // pool larger than the ring gives both repeats and evictions
      for (int unsigned i = 0; i < POOL_SIZE; i++) begin
         pool_len[i] = $urandom_range(1, 6);
         for (int unsigned k = 0; k < MAX_LINE; k++)
            pool_text[i][k] = 8'($urandom_range(0, 255));
      end

      while (items_sent < N_ITEMS) begin
         if ($urandom_range(0, 19) == 0) sender_burst = !sender_burst;
         // long result hold-off while requests keep coming back to back
         if (!pressure_done && items_sent > N_ITEMS / 2) begin
            pressure_done    = 1'b1;
            hold_off_request = 1'b1;
            sender_burst     = 1'b1;
         end
         pick = $urandom_range(0, 99);
         if (pick < 60) begin
            idx = $urandom_range(0, POOL_SIZE - 1);
            send_line(pool_text[idx], pool_len[idx], $urandom_range(0, 4) == 0);
         end else if (pick < 85) begin
            len = $urandom_range(0, MAX_LINE);
            foreach (txt[k]) txt[k] = 8'($urandom_range(0, 255));
            send_line(txt, len, $urandom_range(0, 2) == 0);
         end else if (pick < 92) begin
            send_request(8'($urandom_range(0, 255)), 1'b0, 1'b0);
         end else begin
            send_request(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)));
         end
      end
      req_bus.valid <= 1'b0;

      // drain, then allow for a late stray result
      while (tracker.expected_lines.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (tracker.failures == 0 && tracker.expected_lines.size() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
